// ===== hw/rtl/conv3x3_accumulate_leaky_relu_assert.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef CONV3X3_ACCUMULATE_LEAKY_RELU_ASSERT_SVH
`define CONV3X3_ACCUMULATE_LEAKY_RELU_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define C3LR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define C3LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/c3lr_pkg.sv =====
package c3lr_pkg;

  // Tile limits and derived sizes
  localparam int MAX_TILE_WIDTH  = 128;
  localparam int MAX_TILE_HEIGHT = 16;
  localparam int COL_W     = $clog2(MAX_TILE_WIDTH + 3);
  localparam int ROW_W     = $clog2(MAX_TILE_HEIGHT + 3);
  localparam int RS_DEPTH  = MAX_TILE_WIDTH + 2;
  localparam int RS_AW     = $clog2(RS_DEPTH);
  localparam int ACC_DEPTH = MAX_TILE_WIDTH * MAX_TILE_HEIGHT;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);

  // Fixed-point widths
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int KROWS    = 3;
  localparam int NTAPS    = KROWS * KROWS;
  localparam int CONV_W   = PROD_W + 3;
  localparam int ACC_W    = 48;
  localparam int LEAK_MUL = 6554;

  // Configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 3'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [CONV_W-1:0]   conv_t;
  typedef logic        [CFG_W-1:0]    krow_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Line buffer controls
  typedef struct packed {
    logic rd;
    logic shift;
  } lb_ctl_t;

endpackage

// ===== hw/rtl/c3lr_in_if.sv =====
interface c3lr_in_if import c3lr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first_plane;
  logic    last_plane;

  modport source (output valid, sample, first_plane, last_plane, input ready);
  modport sink (input valid, sample, first_plane, last_plane, output ready);
endinterface

// ===== hw/rtl/c3lr_out_if.sv =====
interface c3lr_out_if import c3lr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t value;
  logic    last_of_tile;

  modport source (output valid, value, last_of_tile, input ready);
  modport sink (input valid, value, last_of_tile, output ready);
endinterface

// ===== hw/rtl/conv3x3_accumulate_leaky_relu.sv =====
// 3x3 convolution stage with accumulation across input planes and leaky ReLU.
// Feed the samples of one input plane of a tile in raster order,
// (tile_width+2) columns by (tile_height+2) rows; the first plane starts each
// output pixel from the bias, the last plane emits one activated, saturated
// Q3.12 pixel per sample in the valid window, last_of_tile on the final one.
// Items are taken one at a time: a border sample (row or column below two)
// passes through a single move state; a window sample runs the nine-step
// multiply-accumulate over one shared 16x16 multiplier plus the accumulator
// memory read-modify-write; with last_plane it also runs the leaky ReLU
// multiply and the output load, and waits while the output is stalled.
// Row history and accumulators are on-chip memories with no clearing pass;
// a plane that is not first must follow a first plane over the same tile.
// Configuration must be written only while idle (not enforced by the block);
// writing tile_width or tile_height restarts the plane at row 0, column 0.
`include "conv3x3_accumulate_leaky_relu_assert.svh"

module conv3x3_accumulate_leaky_relu import c3lr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  c3lr_in_if.sink              in_if,
  c3lr_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int BIAS_SH = 14;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOVE = 6'b000010,
    S_CONV = 6'b000100,
    S_ACC  = 6'b001000,
    S_ACT  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          tile_width_r;
  logic [4:0]          tile_height_r;
  krow_t               kern_r [KROWS];
  sample_t             bias_r;

  logic [COL_W-1:0]    c_r, c_nxt;
  logic [ROW_W-1:0]    r_r, r_nxt;
  logic [ACC_AW-1:0]   pix_r, pix_nxt;
  logic [COL_W-1:0]    w_eff;
  logic [ROW_W-1:0]    h_eff;
  logic                c_last, r_last, win_item;

  sample_t             sample_r;
  logic                first_r, last_r, tile_end_r;
  logic                accept, adv, size_wr;

  lb_ctl_t             lb_ctl;
  sample_t             taps [NTAPS];
  logic                mac_done;
  conv_t               conv;

  acc_t                acc_rd, acc_base, acc_sum;
  logic [ACC_W:0]      acc_wide;
  sample_t             act_y;

  logic                out_valid_r, out_valid_nxt, out_load;
  sample_t             out_value_r;
  logic                out_last_r;

  // Clamp the tile size to the supported range
  always_comb begin
    if (tile_width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (int'(tile_width_r) > MAX_TILE_WIDTH) begin
      w_eff = COL_W'(MAX_TILE_WIDTH);
    end else begin
      w_eff = COL_W'(tile_width_r);
    end
    if (tile_height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (int'(tile_height_r) > MAX_TILE_HEIGHT) begin
      h_eff = ROW_W'(MAX_TILE_HEIGHT);
    end else begin
      h_eff = ROW_W'(tile_height_r);
    end
  end

  // Configuration registers
  assign size_wr = cfg_we && (cfg_index == CFG_TILE_WIDTH || cfg_index == CFG_TILE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r  <= 8'd128;
      tile_height_r <= 5'd16;
      kern_r[0]     <= '0;
      kern_r[1]     <= '0;
      kern_r[2]     <= '0;
      bias_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILE_WIDTH:  tile_width_r  <= cfg_wdata[7:0];
        CFG_TILE_HEIGHT: tile_height_r <= cfg_wdata[4:0];
        CFG_KERNEL_TOP:  kern_r[0]     <= cfg_wdata;
        CFG_KERNEL_MID:  kern_r[1]     <= cfg_wdata;
        CFG_KERNEL_BOT:  kern_r[2]     <= cfg_wdata;
        CFG_BIAS:        bias_r        <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and item classification
  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign win_item    = (r_r >= ROW_W'(2)) && (c_r >= COL_W'(2));
  assign c_last      = (c_r == w_eff + COL_W'(1));
  assign r_last      = (r_r == h_eff + ROW_W'(1));
  assign adv         = (state_r == S_MOVE) || (state_r == S_ACC);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = win_item ? S_CONV : S_MOVE;
      S_MOVE: state_nxt = S_IDLE;
      S_CONV: if (mac_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_ACT : S_IDLE;
      S_ACT:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance column, row and output pixel index at the end of an item
  always_comb begin
    c_nxt   = c_r;
    r_nxt   = r_r;
    pix_nxt = pix_r;
    if (adv) begin
      if (state_r == S_ACC) begin
        pix_nxt = pix_r + ACC_AW'(1);
      end
      if (c_last) begin
        c_nxt = '0;
        if (r_last) begin
          r_nxt   = '0;
          pix_nxt = '0;
        end else begin
          r_nxt = r_r + ROW_W'(1);
        end
      end else begin
        c_nxt = c_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      c_r     <= '0;
      r_r     <= '0;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (size_wr) begin
        c_r   <= '0;
        r_r   <= '0;
        pix_r <= '0;
      end else begin
        c_r   <= c_nxt;
        r_r   <= r_nxt;
        pix_r <= pix_nxt;
      end
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_if.sample;
      first_r  <= in_if.first_plane;
      last_r   <= in_if.last_plane;
    end
    if (state_r == S_ACC) begin
      tile_end_r <= c_last && r_last;
    end
  end

  // Row store and window
  assign lb_ctl.rd    = accept;
  assign lb_ctl.shift = adv;

  c3lr_line_buf u_line_buf (
    .clk    (clk),
    .ctl    (lb_ctl),
    .addr   (c_r[RS_AW-1:0]),
    .sample (sample_r),
    .taps   (taps)
  );

  // Nine-tap multiply-accumulate
  c3lr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && win_item),
    .taps  (taps),
    .kern  (kern_r),
    .done  (mac_done),
    .sum   (conv)
  );

  // Accumulator update: start from bias or stored value, add, saturate
  always_comb begin
    if (first_r) begin
      acc_base = {{(ACC_W-SAMPLE_W-BIAS_SH){bias_r[SAMPLE_W-1]}}, bias_r, {BIAS_SH{1'b0}}};
    end else begin
      acc_base = acc_rd;
    end
    acc_wide = {acc_base[ACC_W-1], acc_base}
             + {{(ACC_W+1-CONV_W){conv[CONV_W-1]}}, conv};
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_sum = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sum = acc_wide[ACC_W-1:0];
    end
  end

  c3lr_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_mem (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (pix_r),
    .wdata (acc_sum),
    .re    (accept),
    .raddr (pix_r),
    .rdata (acc_rd)
  );

  // Leaky ReLU
  c3lr_act u_act (
    .clk    (clk),
    .ld     (state_r == S_ACC),
    .acc_in (acc_sum),
    .y      (act_y)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= act_y;
      out_last_r  <= tile_end_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.value        = out_value_r;
  assign out_if.last_of_tile = out_last_r;

  // Checks
  `C3LR_ASSERT_NOW(a_mac_done_in_conv, mac_done, state_r == S_CONV, "mac done outside conv")
  `C3LR_ASSERT_NOW(a_counters_in_range, 1'b1, (c_r <= w_eff + COL_W'(1)) && (r_r <= h_eff + ROW_W'(1)), "counter beyond tile")
  `C3LR_ASSERT_NOW(a_pixel_index, state_r == S_ACC, int'(pix_r) == (int'(r_r) - 2) * int'(w_eff) + int'(c_r) - 2, "pixel index mismatch")

endmodule

// ===== hw/rtl/c3lr_ram.sv =====
module c3lr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/c3lr_line_buf.sv =====
module c3lr_line_buf import c3lr_pkg::*; (
  input  logic             clk,
  input  lb_ctl_t          ctl,
  input  logic [RS_AW-1:0] addr,
  input  sample_t          sample,
  output sample_t          taps [NTAPS]
);

  logic [2*SAMPLE_W-1:0] rd_data;
  sample_t               cur [KROWS];
  sample_t               win_r [KROWS][2];

  // Two rows of history per column, packed into one word
  c3lr_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (RS_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ctl.shift),
    .waddr (addr),
    .wdata ({sample, cur[1]}),
    .re    (ctl.rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Current column: two stored rows plus the new sample
  always_comb begin
    cur[0] = rd_data[SAMPLE_W-1:0];
    cur[1] = rd_data[2*SAMPLE_W-1:SAMPLE_W];
    cur[2] = sample;
  end

  // Window taps in kernel order, row by row
  always_comb begin
    for (int i = 0; i < KROWS; i++) begin
      taps[KROWS*i]     = win_r[i][0];
      taps[KROWS*i + 1] = win_r[i][1];
      taps[KROWS*i + 2] = cur[i];
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < KROWS; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= cur[i];
      end
    end
  end

endmodule

// ===== hw/rtl/c3lr_mac.sv =====
module c3lr_mac import c3lr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  sample_t taps [NTAPS],
  input  krow_t   kern [KROWS],
  output logic    done,
  output conv_t   sum
);

  localparam int TAP_W = $clog2(NTAPS);

  sample_t                   wts [NTAPS];
  logic [TAP_W-1:0]          tap_r;
  logic                      run_r;
  logic                      pv_r;
  logic                      done_r;
  logic signed [PROD_W-1:0]  prod_r;
  conv_t                     sum_r;

  // Unpack the nine weights
  always_comb begin
    for (int i = 0; i < KROWS; i++) begin
      for (int j = 0; j < KROWS; j++) begin
        wts[KROWS*i + j] = kern[i][SAMPLE_W*j +: SAMPLE_W];
      end
    end
  end

  // Step through the taps, one product per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      tap_r  <= '0;
    end else begin
      pv_r   <= run_r;
      done_r <= pv_r && !run_r;
      if (start) begin
        run_r <= 1'b1;
        tap_r <= '0;
      end else if (run_r) begin
        if (tap_r == TAP_W'(NTAPS - 1)) begin
          run_r <= 1'b0;
        end else begin
          tap_r <= tap_r + TAP_W'(1);
        end
      end
    end
  end

  // Register the product, then add it in
  always_ff @(posedge clk) begin
    prod_r <= taps[tap_r] * wts[tap_r];
    if (start) begin
      sum_r <= '0;
    end else if (pv_r) begin
      sum_r <= sum_r + {{(CONV_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

// ===== hw/rtl/c3lr_act.sv =====
module c3lr_act import c3lr_pkg::*; (
  input  logic    clk,
  input  logic    ld,
  input  acc_t    acc_in,
  output sample_t y
);

  localparam int FRAC_SH = 14;
  localparam int NEG_SH  = 30;
  localparam int SPLIT   = 24;
  localparam int HI_W    = ACC_W - SPLIT;
  localparam int LM_W    = $clog2(LEAK_MUL + 1);
  localparam int PHI_W   = HI_W + LM_W + 1;
  localparam int PLO_W   = SPLIT + LM_W;
  localparam int TOT_W   = PHI_W + SPLIT;
  localparam int POS_W   = ACC_W + 1 - FRAC_SH;
  localparam int Y_W     = TOT_W - NEG_SH;

  acc_t                     acc_r;
  logic                     neg_r;
  logic [POS_W-1:0]         pos_q_r;
  logic signed [PHI_W-1:0]  p_hi_r;
  logic [PLO_W-1:0]         p_lo_r;
  logic signed [HI_W-1:0]   hi;
  logic signed [LM_W:0]     lm;
  logic [ACC_W:0]           pos_sum;
  logic signed [TOT_W-1:0]  tot;
  logic signed [Y_W-1:0]    yneg;

  // Split the accumulator so each multiply stays narrow
  always_comb begin
    hi      = acc_r[ACC_W-1:SPLIT];
    lm      = (LM_W+1)'(LEAK_MUL);
    pos_sum = {1'b0, acc_r} + ((ACC_W+1)'(1) << (FRAC_SH - 1));
  end

  // Hold the accumulator, then form partial products
  always_ff @(posedge clk) begin
    if (ld) begin
      acc_r <= acc_in;
    end
    neg_r   <= acc_r[ACC_W-1];
    pos_q_r <= pos_sum[ACC_W:FRAC_SH];
    p_hi_r  <= hi * lm;
    p_lo_r  <= acc_r[SPLIT-1:0] * LM_W'(LEAK_MUL);
  end

  // Round half up and saturate
  always_comb begin
    tot  = {p_hi_r, {SPLIT{1'b0}}} + {{(TOT_W-PLO_W){1'b0}}, p_lo_r}
         + (TOT_W'(1) << (NEG_SH - 1));
    yneg = tot[TOT_W-1:NEG_SH];
    if (neg_r) begin
      if (yneg < -(Y_W'(32768))) begin
        y = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        y = yneg[SAMPLE_W-1:0];
      end
    end else begin
      if (pos_q_r > POS_W'(32767)) begin
        y = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        y = pos_q_r[SAMPLE_W-1:0];
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c3lr_pkg::*;

  localparam int ITEMS_TOTAL   = 1700;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;

  typedef enum int {SMP_FULL, SMP_SMALL, SMP_EXTREME, SMP_MAX, SMP_MIN} sample_mode_e;

  typedef struct packed {
    sample_t value;
    logic    last_of_tile;
  } pixel_t;

  // Predicts the output pixels of the layer stage and checks them in order
  class pixel_scoreboard;
    logic [7:0] width_reg;
    logic [4:0] height_reg;
    krow_t      kernel [KROWS];
    sample_t    bias;
    longint     line_buf [2][RS_DEPTH];
    longint     window [KROWS][2];
    longint     acc_mem [ACC_DEPTH];
    int         col;
    int         row;
    pixel_t     expected_pixels [$];
    int         errors;
    int         checked;

    function new();
      width_reg  = MAX_TILE_WIDTH;
      height_reg = MAX_TILE_HEIGHT;
      bias       = '0;
      col        = 0;
      row        = 0;
      errors     = 0;
      checked    = 0;
      foreach (kernel[i]) kernel[i] = '0;
      foreach (line_buf[i, j]) line_buf[i][j] = 0;
      foreach (window[i, j]) window[i][j] = 0;
      foreach (acc_mem[i]) acc_mem[i] = 0;
    endfunction

    function int cols();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_TILE_WIDTH) w = MAX_TILE_WIDTH;
      return w;
    endfunction

    function int rows();
      int h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_TILE_HEIGHT) h = MAX_TILE_HEIGHT;
      return h;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function longint weight(int i, int j);
      sample_t k;
      k = kernel[i][j*SAMPLE_W +: SAMPLE_W];
      return k;
    endfunction

    function longint saturate_acc(longint v);
      if (v > longint'(ACC_MAX)) return longint'(ACC_MAX);
      if (v < longint'(ACC_MIN)) return longint'(ACC_MIN);
      return v;
    endfunction

    // Leaky ReLU with half-up rounding, then clip to Q3.12
    function sample_t activate(longint a);
      longint y;
      if (a >= 0) y = (a + (longint'(1) <<< 13)) >>> 14;
      else y = (a * LEAK_MUL + (longint'(1) <<< 29)) >>> 30;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return sample_t'(y);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, krow_t data);
      case (idx)
        CFG_TILE_WIDTH: begin
          width_reg = data[7:0];
          col = 0;
          row = 0;
        end
        CFG_TILE_HEIGHT: begin
          height_reg = data[4:0];
          col = 0;
          row = 0;
        end
        CFG_KERNEL_TOP: kernel[0] = data;
        CFG_KERNEL_MID: kernel[1] = data;
        CFG_KERNEL_BOT: kernel[2] = data;
        CFG_BIAS:       bias = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the window by one accepted sample and queue its pixel, if any
    function void take_sample(sample_t s, bit is_first, bit is_last);
      int     w, h, c, r, idx;
      longint cur [KROWS];
      longint conv, acc;
      pixel_t p;
      w = cols();
      h = rows();
      c = col;
      r = row;
      if (c >= w + 2) c = 0;
      if (r >= h + 2) r = 0;
      cur[0] = line_buf[0][c];
      cur[1] = line_buf[1][c];
      cur[2] = s;
      if (r >= 2 && c >= 2) begin
        conv = 0;
        for (int i = 0; i < KROWS; i++) begin
          conv += window[i][0] * weight(i, 0) + window[i][1] * weight(i, 1)
                  + cur[i] * weight(i, 2);
        end
        idx = (r - 2) * w + (c - 2);
        if (idx >= ACC_DEPTH) idx = 0;
        acc = is_first ? saturate_acc(longint'(bias) <<< 14) : acc_mem[idx];
        acc = saturate_acc(acc + conv);
        acc_mem[idx] = acc;
        if (is_last) begin
          p.value = activate(acc);
          p.last_of_tile = (r == h + 1 && c == w + 1);
          expected_pixels.push_back(p);
        end
      end
      line_buf[0][c] = cur[1];
      line_buf[1][c] = cur[2];
      for (int i = 0; i < KROWS; i++) begin
        window[i][0] = window[i][1];
        window[i][1] = cur[i];
      end
      c++;
      if (c >= w + 2) begin
        c = 0;
        r++;
        if (r >= h + 2) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_pixel(sample_t v, logic is_last);
      pixel_t p;
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("output pixel %0d arrived with none expected", v));
        return;
      end
      p = expected_pixels.pop_front();
      checked++;
      if (p.value !== v || p.last_of_tile !== is_last)
        note_failure($sformatf("pixel %0d: value expected %0d got %0d, last_of_tile expected %0b got %0b",
                               checked, p.value, v, p.last_of_tile, is_last));
    endfunction

    function void final_check();
      if (expected_pixels.size() != 0)
        note_failure($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  c3lr_in_if  in_if ();
  c3lr_out_if out_if ();

  conv3x3_accumulate_leaky_relu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_scoreboard sb;
  int send_idle_pct = 38;
  int recv_idle_pct = 69;
  bit hold_request  = 1'b0;
  bit hold_done     = 1'b0;
  int items_sent    = 0;
  int jobs_run      = 0;
  int kernel_swaps  = 0;
  int cut_planes    = 0;
  int cycles        = 0;
  bit acc_written [ACC_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // Receiver: check each accepted pixel, then drive ready for the next edge
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_pixel(out_if.value, out_if.last_of_tile);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic krow_t with_noise(krow_t v, int bits);
    logic [63:0] r;
    krow_t       m;
    r = {$urandom, $urandom};
    m = (krow_t'(1) << bits) - 1;
    return (r[CFG_W-1:0] & ~m) | (v & m);
  endfunction

  function automatic krow_t random_kernel_row(bit small_w);
    logic [63:0] r;
    krow_t       row_bits;
    r = {$urandom, $urandom};
    row_bits = r[CFG_W-1:0];
    if (small_w) begin
      for (int j = 0; j < KROWS; j++)
        row_bits[j*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(16383) - 8192);
    end
    return row_bits;
  endfunction

  function automatic sample_t pick_sample(sample_mode_e mode);
    case (mode)
      SMP_SMALL: return sample_t'($urandom_range(8191) - 4096);
      SMP_MAX:   return SAMPLE_MAX;
      SMP_MIN:   return SAMPLE_MIN;
      SMP_EXTREME: begin
        case ($urandom_range(3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          default: return sample_t'($urandom);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input krow_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic apply_tile(input logic [7:0] wraw, input logic [4:0] hraw);
    write_reg(CFG_TILE_WIDTH, with_noise(krow_t'(wraw), 8));
    write_reg(CFG_TILE_HEIGHT, with_noise(krow_t'(hraw), 5));
  endtask

  task automatic write_kernel(input bit small_w);
    write_reg(CFG_KERNEL_TOP, random_kernel_row(small_w));
    write_reg(CFG_KERNEL_MID, random_kernel_row(small_w));
    write_reg(CFG_KERNEL_BOT, random_kernel_row(small_w));
    write_reg(CFG_BIAS, with_noise(krow_t'($urandom), SAMPLE_W));
  endtask

  // Drop valid and wait until every pixel is out and the block is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s, input bit is_first, input bit is_last);
    // idle before offering the item
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.first_plane <= is_first;
    in_if.last_plane  <= is_last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.take_sample(s, is_first, is_last);
    items_sent++;
  endtask

  // Stream one input plane in raster order, optionally cut short or with a
  // kernel swap partway through
  task automatic run_plane(input bit is_first, input bit is_last, input bit noisy,
                           input int stop_at, input int rekernel_at,
                           input sample_mode_e mode, input bit small_w);
    int w, h, n, r, c, idx;
    bit f, l;
    w = sb.cols();
    h = sb.rows();
    n = (w + 2) * (h + 2);
    for (int k = 0; k < n; k++) begin
      if (k == stop_at) begin
        cut_planes++;
        break;
      end
      if (k == rekernel_at) begin
        settle();
        write_kernel(small_w);
        cfg_we <= 1'b0;
        kernel_swaps++;
      end
      r = k / (w + 2);
      c = k % (w + 2);
      f = is_first;
      l = is_last;
      if (noisy) begin
        f = $urandom_range(1);
        l = $urandom_range(1);
      end
      // never let a pixel accumulate onto an entry that was never started
      if (r >= 2 && c >= 2) begin
        idx = (r - 2) * w + (c - 2);
        if (!acc_written[idx]) f = 1'b1;
        acc_written[idx] = 1'b1;
      end
      send_sample(pick_sample(mode), f, l);
    end
  endtask

  // One tile: new size and kernel, then one to three planes
  task automatic random_job(input bit hold);
    logic [7:0]   wraw;
    logic [4:0]   hraw;
    int           kind, planes, n, stop_at, rekernel_at;
    bit           small_w;
    sample_mode_e mode;
    kind = (jobs_run < 2) ? jobs_run : $urandom_range(24);
    case (kind)
      0: begin
        wraw = $urandom_range(255, MAX_TILE_WIDTH);
        hraw = $urandom_range(1);
      end
      1: begin
        wraw = $urandom_range(1);
        hraw = $urandom_range(31, MAX_TILE_HEIGHT);
      end
      default: begin
        wraw = $urandom_range(8, 1);
        hraw = $urandom_range(4, 1);
      end
    endcase
    planes  = (kind < 2 || hold) ? 1 : $urandom_range(3, 1);
    small_w = $urandom_range(1);
    mode    = sample_mode_e'($urandom_range(SMP_EXTREME));
    settle();
    apply_tile(wraw, hraw);
    write_kernel(small_w);
    cfg_we <= 1'b0;
    if (hold) hold_request = 1'b1;
    for (int p = 0; p < planes; p++) begin
      if (p > 0 && $urandom_range(99) < 30) begin
        settle();
        write_kernel(small_w);
        cfg_we <= 1'b0;
      end
      n = (sb.cols() + 2) * (sb.rows() + 2);
      stop_at     = ($urandom_range(99) < 8) ? $urandom_range(n - 1, 1) : -1;
      rekernel_at = ($urandom_range(99) < 8) ? $urandom_range(n - 1, 1) : -1;
      run_plane(p == 0, p == planes - 1, $urandom_range(99) < 15, stop_at, rekernel_at,
                mode, small_w);
      if (stop_at >= 0) break;
    end
    jobs_run++;
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.first_plane <= 1'b0;
    in_if.last_plane  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest tile with the kernel and bias still at their reset values
    apply_tile(8'd1, 5'd1);
    cfg_we <= 1'b0;
    run_plane(1'b1, 1'b1, 1'b0, -1, -1, SMP_EXTREME, 1'b0);
    settle();

    // Zero tile size clamps to one; most negative weights and bias; writes
    // past the register list are ignored; accumulate without emitting
    apply_tile(8'd0, 5'd0);
    write_reg(CFG_KERNEL_TOP, {KROWS{SAMPLE_MIN}});
    write_reg(CFG_KERNEL_MID, {KROWS{SAMPLE_MIN}});
    write_reg(CFG_KERNEL_BOT, {KROWS{SAMPLE_MIN}});
    write_reg(CFG_BIAS, with_noise(krow_t'(SAMPLE_MIN), SAMPLE_W));
    write_reg(CFG_SPARE_LO, with_noise('0, 0));
    write_reg(CFG_SPARE_HI, with_noise('0, 0));
    cfg_we <= 1'b0;
    run_plane(1'b1, 1'b0, 1'b0, -1, -1, SMP_MAX, 1'b0);
    settle();

    // Continue the same pixels with the largest weights and emit: the
    // negative side of the activation saturates
    write_reg(CFG_KERNEL_TOP, {KROWS{SAMPLE_MAX}});
    write_reg(CFG_KERNEL_MID, {KROWS{SAMPLE_MAX}});
    write_reg(CFG_KERNEL_BOT, {KROWS{SAMPLE_MAX}});
    cfg_we <= 1'b0;
    run_plane(1'b0, 1'b1, 1'b0, -1, -1, SMP_MIN, 1'b0);
    settle();

    // Random tiles through three idling phases
    while (items_sent < ITEMS_TOTAL) begin
      if (items_sent >= 2 * ITEMS_TOTAL / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEMS_TOTAL / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 38;
      end
      if (send_idle_pct == 0 && !hold_done) begin
        hold_done = 1'b1;
        random_job(1'b1);
      end else begin
        random_job(1'b0);
      end
    end
    settle();
    sb.final_check();

    $display("Checked %0d output pixels from %0d input samples over %0d random tiles,",
             sb.checked, items_sent, jobs_run);
    $display("with %0d mid-plane kernel swaps, %0d cut-short planes and a %0d-cycle output stall.",
             kernel_swaps, cut_planes, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
